// ===== rtl/bdq_pkg.sv =====
// bdq_pkg: shared types and codes for the bounded double-ended queue
// no dependencies; imported by the channel interfaces and all rtl modules
package bdq_pkg;

	localparam int VAL_W = 32;
	localparam int CAP_W = 5;
	localparam int KIND_W = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic [KIND_W-1:0] KIND_INS_FRONT = KIND_W'(0);
	localparam logic [KIND_W-1:0] KIND_INS_REAR = KIND_W'(1);
	localparam logic [KIND_W-1:0] KIND_DEL_FRONT = KIND_W'(2);
	localparam logic [KIND_W-1:0] KIND_DEL_REAR = KIND_W'(3);

	typedef logic [KIND_W-1:0] kind_t;
	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [CAP_W-1:0] cap_t;

	// status of one action, after it took effect
	typedef struct packed {
		logic ok;
		logic is_empty;
		logic is_full;
	} res_t;

endpackage

// ===== rtl/bdq_req_if.sv =====
// bdq_req_if: request channel (action kind and value) with valid/ready
// depends on bdq_pkg
interface bdq_req_if import bdq_pkg::*; ();
	logic valid;
	logic ready;
	kind_t kind;
	val_t value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface

// ===== rtl/bdq_rsp_if.sv =====
// bdq_rsp_if: response channel (status, front and rear values) with valid/ready
// depends on bdq_pkg
interface bdq_rsp_if import bdq_pkg::*; ();
	logic valid;
	logic ready;
	logic ok;
	val_t front_value;
	val_t rear_value;
	logic is_empty;
	logic is_full;

	modport source (output valid, output ok, output front_value, output rear_value,
		output is_empty, output is_full, input ready);
	modport sink (input valid, input ok, input front_value, input rear_value,
		input is_empty, input is_full, output ready);
endinterface

// ===== rtl/bdq_ram.sv =====
// bdq_ram: slot storage, one write port and two registered read ports
// write-first on a same-address collision; depends on bdq_pkg
module bdq_ram import bdq_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  val_t             wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] ra_front,
	input  logic [IDX_W-1:0] ra_rear,
	output val_t             rd_front,
	output val_t             rd_rear
);

	val_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_front <= (we && waddr == ra_front) ? wdata : mem[ra_front];
			rd_rear <= (we && waddr == ra_rear) ? wdata : mem[ra_rear];
		end
	end

endmodule

// ===== rtl/bdq_ctrl.sv =====
// bdq_ctrl: head index, count and capacity registers; decides each action
// and drives the slot write and the front/rear read addresses; depends on bdq_pkg
module bdq_ctrl import bdq_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4,
	parameter int CNT_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  cap_t             cfg_data,
	input  logic             acc,
	input  kind_t            kind,
	input  val_t             value,
	output logic             we,
	output logic [IDX_W-1:0] waddr,
	output val_t             wdata,
	output logic [IDX_W-1:0] ra_front,
	output logic [IDX_W-1:0] ra_rear,
	output res_t             res
);

	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
	localparam logic [IDX_W:0] DEPTH_S = (IDX_W+1)'(DEPTH);

	logic [IDX_W-1:0] head_q, head_n;
	logic [CNT_W-1:0] count_q, count_n;
	cap_t cap_q;
	logic [CMP_W-1:0] eff_cap, count_ext, count_n_ext;
	logic has_room, ok;

	// both operands below DEPTH, so one subtract wraps
	function automatic logic [IDX_W-1:0] ring_add(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= DEPTH_S) begin
			s = s - DEPTH_S;
		end
		return s[IDX_W-1:0];
	endfunction

	always_comb begin
		eff_cap = (CMP_W'(cap_q) > DEPTH_C) ? DEPTH_C : CMP_W'(cap_q);
		count_ext = CMP_W'(count_q);
		has_room = count_ext < eff_cap;
		head_n = head_q;
		count_n = count_q;
		ok = 1'b1;
		we = 1'b0;
		waddr = ring_add(head_q, count_q[IDX_W-1:0]);
		case (kind)
			KIND_INS_FRONT: begin
				if (has_room) begin
					head_n = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - IDX_W'(1);
					count_n = count_q + CNT_W'(1);
					waddr = head_n;
					we = acc;
				end else begin
					ok = 1'b0;
				end
			end
			KIND_INS_REAR: begin
				if (has_room) begin
					count_n = count_q + CNT_W'(1);
					we = acc;
				end else begin
					ok = 1'b0;
				end
			end
			KIND_DEL_FRONT: begin
				if (count_q != '0) begin
					head_n = ring_add(head_q, IDX_W'(1));
					count_n = count_q - CNT_W'(1);
				end else begin
					ok = 1'b0;
				end
			end
			KIND_DEL_REAR: begin
				if (count_q != '0) begin
					count_n = count_q - CNT_W'(1);
				end else begin
					ok = 1'b0;
				end
			end
			default: begin
			end
		endcase
		count_n_ext = CMP_W'(count_n);
		wdata = value;
		ra_front = head_n;
		// rear offset is count minus one; only meaningful when not empty
		ra_rear = ring_add(head_n, IDX_W'(count_n - CNT_W'(1)));
		res.ok = ok;
		res.is_empty = (count_n == '0);
		res.is_full = (count_n_ext >= eff_cap);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			cap_q <= CAP_RESET;
		end else begin
			if (acc) begin
				head_q <= head_n;
				count_q <= count_n;
			end
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
		end
	end

endmodule

// ===== rtl/bounded_double_ended_queue.sv =====
// bounded_double_ended_queue: ring-buffer deque of signed 32-bit values
// depends on bdq_pkg, bdq_req_if, bdq_rsp_if, bdq_ctrl, bdq_ram
//
//   channel  dir   handshake      payload
//   req      in    valid/ready    kind, value
//   rsp      out   valid/ready    ok, front_value, rear_value, is_empty, is_full
//   cfg      in    cfg_we         cfg_data (capacity)
//
// one item per cycle while rsp is not stalled; the slot write and both reads happen at the
// accept edge, the read data and status are registered in the read stage, then they move
// into the output register that drives rsp.
// reset clears head, count and the pipeline; capacity resets to 16; slots are not cleared.
// a stalled response holds req ready low once the read stage is also occupied.
module bounded_double_ended_queue import bdq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  cap_t      cfg_data,
	bdq_req_if.sink   req,
	bdq_rsp_if.source rsp
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic acc, move;
	logic we;
	logic [IDX_W-1:0] waddr, ra_front, ra_rear;
	val_t wdata, rd_front, rd_rear;
	res_t res, res_s1;
	logic valid_s1;
	logic out_valid_q;
	res_t out_res_q;
	val_t out_front_q, out_rear_q;

	assign move = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || move;
	assign acc = req.valid && req.ready;

	bdq_ctrl #(.DEPTH(DEPTH), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.acc      (acc),
		.kind     (req.kind),
		.value    (req.value),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata),
		.ra_front (ra_front),
		.ra_rear  (ra_rear),
		.res      (res)
	);

	bdq_ram #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_ram (
		.clk      (clk),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata),
		.re       (acc),
		.ra_front (ra_front),
		.ra_rear  (ra_rear),
		.rd_front (rd_front),
		.rd_rear  (rd_rear)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res;
		end
		if (move) begin
			out_res_q <= res_s1;
			// empty deque reports all ones for both ends
			out_front_q <= res_s1.is_empty ? '1 : rd_front;
			out_rear_q <= res_s1.is_empty ? '1 : rd_rear;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.ok = out_res_q.ok;
	assign rsp.is_empty = out_res_q.is_empty;
	assign rsp.is_full = out_res_q.is_full;
	assign rsp.front_value = out_front_q;
	assign rsp.rear_value = out_rear_q;

endmodule
